// File: rtl/core/gau_pkg.sv
`default_nettype none

package gau_pkg;

    // Width of the column/row counters and of the held glyph dimensions.
    localparam int COORD_BITS = 8;

    // Entries in the queue between the front end and the expander.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        DEPTH_1 = 2'd0,
        DEPTH_2 = 2'd1,
        DEPTH_4 = 2'd2,
        DEPTH_8 = 2'd3
    } t_depth;

    // One classified input byte as it travels through the queue.
    typedef struct packed {
        logic [7:0]            data;
        logic                  start;
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
        t_depth                depth;
        logic                  supported;
        logic [2:0]            last_idx;
    } t_item;

    // One expanded pixel.
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] column;
        logic [7:0] row;
        logic       row_end;
        logic       glyph_end;
        logic       last_of_byte;
    } t_pixel;

endpackage

`default_nettype wire

// File: rtl/core/gau_front.sv
`default_nettype none

module gau_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [3:0]           i_cfg_wr_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_glyph_start,
    input  wire logic [7:0]           i_glyph_width,
    input  wire logic [7:0]           i_glyph_height,
    output gau_pkg::t_item            o_item,
    output logic                      o_valid,
    input  wire logic                 i_take
);

    logic [3:0]                        r_bpp;
    gau_pkg::t_item                    r_mem [gau_pkg::QUEUE_DEPTH];
    logic [gau_pkg::QUEUE_AW-1:0]      r_wr_ptr;
    logic [gau_pkg::QUEUE_AW-1:0]      r_rd_ptr;
    logic [gau_pkg::QUEUE_AW:0]        r_count;
    logic [gau_pkg::QUEUE_AW-1:0]      n_wr_ptr;
    logic [gau_pkg::QUEUE_AW-1:0]      n_rd_ptr;
    logic [gau_pkg::QUEUE_AW:0]        n_count;
    gau_pkg::t_item                    w_item;
    logic                              w_push_ok;
    logic                              w_pop_ok;

    // Classify the byte by the current pixel depth.
    always_comb begin
        w_item.data      = i_data_byte;
        w_item.start     = i_glyph_start;
        w_item.width     = gau_pkg::COORD_BITS'(i_glyph_width);
        w_item.height    = gau_pkg::COORD_BITS'(i_glyph_height);
        w_item.supported = 1'b1;
        case (r_bpp)
            4'd1: begin
                w_item.depth    = gau_pkg::DEPTH_1;
                w_item.last_idx = 3'd7;
            end
            4'd2: begin
                w_item.depth    = gau_pkg::DEPTH_2;
                w_item.last_idx = 3'd3;
            end
            4'd4: begin
                w_item.depth    = gau_pkg::DEPTH_4;
                w_item.last_idx = 3'd1;
            end
            4'd8: begin
                w_item.depth    = gau_pkg::DEPTH_8;
                w_item.last_idx = 3'd0;
            end
            default: begin
                w_item.depth     = gau_pkg::DEPTH_8;
                w_item.last_idx  = 3'd0;
                w_item.supported = 1'b0;
            end
        endcase
    end

    assign full      = (r_count == (gau_pkg::QUEUE_AW+1)'(gau_pkg::QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_item    = r_mem[r_rd_ptr];
    assign w_push_ok = push && !full;
    assign w_pop_ok  = i_take && o_valid;

    always_comb begin
        n_wr_ptr = w_push_ok ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop_ok  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_push_ok && !w_pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (!w_push_ok && w_pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp    <= 4'd1;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_bpp <= i_cfg_wr_data;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/gau_back.sv
`default_nettype none

module gau_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire gau_pkg::t_item  i_item,
    input  wire logic            i_valid,
    output logic                 o_take,
    output gau_pkg::t_pixel      o_pixel,
    output logic                 empty,
    input  wire logic            pop
);

    localparam int CW = gau_pkg::COORD_BITS;

    logic                  r_busy;
    logic                  r_active;
    logic [CW-1:0]         r_col;
    logic [CW-1:0]         r_row;
    logic [CW-1:0]         r_w;
    logic [CW-1:0]         r_h;
    logic                  r_out_valid;
    logic [7:0]            r_bits;
    logic [2:0]            r_k;
    logic [2:0]            r_last_idx;
    gau_pkg::t_depth       r_depth;
    gau_pkg::t_pixel       r_out;

    logic                  n_busy;
    logic                  n_active;
    logic [CW-1:0]         n_col;
    logic [CW-1:0]         n_row;
    logic [CW-1:0]         n_w;
    logic [CW-1:0]         n_h;
    logic                  n_out_valid;
    logic [7:0]            n_bits;
    logic [2:0]            n_k;
    logic [2:0]            n_last_idx;
    gau_pkg::t_depth       n_depth;
    gau_pkg::t_pixel       n_out;

    logic                  w_adv;
    logic                  w_emit;
    logic                  w_rend;
    logic                  w_gend;
    logic                  w_last;
    logic                  w_take;
    logic [7:0]            w_alpha;

    always_comb begin
        case (r_depth)
            gau_pkg::DEPTH_1: w_alpha = {8{r_bits[7]}};
            gau_pkg::DEPTH_2: w_alpha = {4{r_bits[7:6]}};
            gau_pkg::DEPTH_4: w_alpha = {2{r_bits[7:4]}};
            default:          w_alpha = r_bits;
        endcase
    end

    assign w_adv  = !r_out_valid || pop;
    assign w_emit = r_busy && w_adv;
    assign w_rend = (r_col == r_w - CW'(1));
    assign w_gend = w_rend && (r_row == r_h - CW'(1));
    assign w_last = w_gend || (r_k == r_last_idx);
    assign w_take = i_valid && (!r_busy || (w_emit && w_last));

    always_comb begin
        n_busy      = r_busy;
        n_active    = r_active;
        n_col       = r_col;
        n_row       = r_row;
        n_w         = r_w;
        n_h         = r_h;
        n_out_valid = r_out_valid;
        n_bits      = r_bits;
        n_k         = r_k;
        n_last_idx  = r_last_idx;
        n_depth     = r_depth;
        n_out       = r_out;

        if (w_adv) begin
            n_out_valid        = w_emit;
            n_out.alpha        = w_alpha;
            n_out.column       = 8'(r_col);
            n_out.row          = 8'(r_row);
            n_out.row_end      = w_rend;
            n_out.glyph_end    = w_gend;
            n_out.last_of_byte = w_last;
        end

        // Advance the counters past the pixel just issued.
        if (w_emit) begin
            if (w_gend) begin
                n_active = 1'b0;
                n_col    = '0;
                n_row    = '0;
            end else if (w_rend) begin
                n_col = '0;
                n_row = r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
            case (r_depth)
                gau_pkg::DEPTH_1: n_bits = {r_bits[6:0], 1'b0};
                gau_pkg::DEPTH_2: n_bits = {r_bits[5:0], 2'b0};
                gau_pkg::DEPTH_4: n_bits = {r_bits[3:0], 4'b0};
                default:          n_bits = r_bits;
            endcase
            n_k = r_k + 3'd1;
            if (w_last) begin
                n_busy = 1'b0;
            end
        end

        // Load the next byte; a start overrides the counter update above.
        if (w_take) begin
            if (i_item.start) begin
                n_w      = i_item.width;
                n_h      = i_item.height;
                n_col    = '0;
                n_row    = '0;
                n_active = (i_item.width != '0) && (i_item.height != '0);
            end
            n_busy     = i_item.supported && n_active;
            n_bits     = i_item.data;
            n_k        = 3'd0;
            n_last_idx = i_item.last_idx;
            n_depth    = i_item.depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_active    <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_w         <= '0;
            r_h         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_active    <= n_active;
            r_col       <= n_col;
            r_row       <= n_row;
            r_w         <= n_w;
            r_h         <= n_h;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits     <= n_bits;
        r_k        <= n_k;
        r_last_idx <= n_last_idx;
        r_depth    <= n_depth;
        r_out      <= n_out;
    end

    assign o_take  = w_take;
    assign o_pixel = r_out;
    assign empty   = !r_out_valid;

endmodule

`default_nettype wire

// File: rtl/core/glyph_alpha_unpacker.sv
// Expands packed glyph bitmap bytes (1, 2, 4 or 8 bits per pixel, MSB first,
// continuous across rows) into 8-bit alpha pixels tagged with column, row,
// row end, glyph end and last-of-byte. Write bits_per_pixel only while the
// block is idle. A byte with glyph_start high loads width and height and
// restarts the counters; bytes after the glyph end, bytes of an empty glyph
// and bytes at an unsupported depth produce no pixels. Bytes enter through a
// four-entry queue; the expander issues one pixel per clock, while the
// single output register is empty or popped; a byte yields up to 8
// pixels at 1 bpp, 4 at 2 bpp, 2 at 4 bpp and 1 at 8 bpp, and a new byte
// is taken in the cycle its last pixel issues. The first pixel of a byte
// passes through the queue, the expander's byte register and the output
// register before it appears.
`default_nettype none

module glyph_alpha_unpacker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [3:0]  i_cfg_wr_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_glyph_start,
    input  wire logic [7:0]  i_glyph_width,
    input  wire logic [7:0]  i_glyph_height,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_alpha,
    output logic [7:0]       o_column,
    output logic [7:0]       o_row,
    output logic             o_row_end,
    output logic             o_glyph_end,
    output logic             o_last_of_byte
);

    gau_pkg::t_item  w_item;
    logic            w_item_valid;
    logic            w_take;
    gau_pkg::t_pixel w_pixel;

    // Front end: hold the depth register, classify each byte, queue it.
    gau_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_glyph_start  (i_glyph_start),
        .i_glyph_width  (i_glyph_width),
        .i_glyph_height (i_glyph_height),
        .o_item         (w_item),
        .o_valid        (w_item_valid),
        .i_take         (w_take)
    );

    // Back end: track position in the glyph and issue one pixel per transaction.
    gau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_item),
        .i_valid (w_item_valid),
        .o_take  (w_take),
        .o_pixel (w_pixel),
        .empty   (empty),
        .pop     (pop)
    );

    assign o_alpha        = w_pixel.alpha;
    assign o_column       = w_pixel.column;
    assign o_row          = w_pixel.row;
    assign o_row_end      = w_pixel.row_end;
    assign o_glyph_end    = w_pixel.glyph_end;
    assign o_last_of_byte = w_pixel.last_of_byte;

endmodule

`default_nettype wire
